// File: rtl/assert_macros.svh
// Assertion macros shared by the frame store RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/rfps_pkg.sv
// Package for the rotated frame store: panel geometry, derived widths,
// command and register codes, controller state type. No dependencies.
package rfps_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 176;
    localparam int PANEL_HEIGHT = 264;
    localparam int BAND_HEIGHT  = 264;
    localparam int STORE_BYTES  = 5808;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 16;
    localparam int COLOUR_W = 16;
    localparam int BIDX_W  = 13;
    localparam int ROT_W   = 2;
    localparam int PAGE_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Derived widths
    localparam int MAX_DIM  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int YMAX     = (PANEL_HEIGHT > BAND_HEIGHT) ? PANEL_HEIGHT : BAND_HEIGHT;
    localparam int Y_W      = ($clog2(YMAX) > 0) ? $clog2(YMAX) : 1;
    localparam int OFF_RAW  = (PAGE_W - 1) + $clog2(BAND_HEIGHT + 1);
    localparam int SUB_W    = ((OFF_RAW > COORD_W) ? OFF_RAW : COORD_W) + 1;
    localparam int ROW_BYTES = PANEL_WIDTH / 8;
    localparam int IDX_A    = Y_W + $clog2(ROW_BYTES + 1) + 1;
    localparam int IDX_B    = (BIDX_W > $clog2(STORE_BYTES + 1)) ? BIDX_W
                                                                : $clog2(STORE_BYTES + 1);
    localparam int IDX_W    = ((IDX_A > IDX_B) ? IDX_A : IDX_B) + 1;
    localparam int ADDR_W   = ($clog2(STORE_BYTES) > 0) ? $clog2(STORE_BYTES) : 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PLOT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // Rotation codes
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SELECT = 2'd1;

    localparam logic [PAGE_W-1:0] PAGE_RESET = 5'h1F;

    // Controller states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MAP,
        ST_INDEX,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

// File: rtl/rotated_framebuffer_pixel_store_top.sv
// A word passes the map, index, read and write states, then the output register.
// Only one word is in flight; the single-port store does one read-modify-write.
// A fill returns its result, then sweeps the store and writes the fill value to every byte.
// Reset: control clears at once, then a clearing pass writes zero to the store; no word
// is taken during it, configuration writes are.
// Depends on rfps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rotated_framebuffer_pixel_store_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rfps_pkg::CMD_W-1:0]          command,
    input  logic signed [rfps_pkg::POS_W-1:0]   pos_x,
    input  logic signed [rfps_pkg::POS_W-1:0]   pos_y,
    input  logic [rfps_pkg::COLOUR_W-1:0]       colour,
    input  logic [rfps_pkg::BIDX_W-1:0]         byte_index,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          read_byte,
    output logic                                pixel_taken,
    // configuration
    input  logic                                cfg_write,
    input  logic [rfps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COORD_W = rfps_pkg::COORD_W;
    localparam int Y_W     = rfps_pkg::Y_W;
    localparam int SUB_W   = rfps_pkg::SUB_W;
    localparam int IDX_W   = rfps_pkg::IDX_W;
    localparam int ADDR_W  = rfps_pkg::ADDR_W;
    localparam int POS_W   = rfps_pkg::POS_W;

    rfps_pkg::state_t state_reg, state_next;

    // Configuration
    logic [rfps_pkg::ROT_W-1:0]  rotation_reg;
    logic [rfps_pkg::PAGE_W-1:0] page_select_reg;

    // Captured word
    logic [rfps_pkg::CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]            pos_x_reg;
    logic [POS_W-1:0]            pos_y_reg;
    logic                        black_reg;
    logic [rfps_pkg::BIDX_W-1:0] bidx_reg;

    // Mapping stage
    logic [COORD_W-1:0] map_x_reg, map_x_next;
    logic [Y_W-1:0]     map_y_reg, map_y_next;
    logic               map_ok_reg, map_ok_next;

    // Index stage
    logic [ADDR_W-1:0]  idx_reg;
    logic               hit_reg;
    logic [7:0]         mask_reg;
    logic [IDX_W-1:0]   idx_full;
    logic               hit_next;

    // Sweep
    logic [ADDR_W-1:0]  sweep_cnt_reg;
    logic [7:0]         fill_val_reg;
    logic               sweep_last;

    // Store
    logic [7:0]         mem [rfps_pkg::STORE_BYTES];
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    logic [7:0]         mem_wdata;

    // Output register
    logic               out_valid_reg;
    logic [7:0]         read_byte_reg;
    logic               pixel_taken_reg;
    logic               out_free;
    logic               out_load;
    logic               accept;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign sweep_last = (sweep_cnt_reg == ADDR_W'(rfps_pkg::STORE_BYTES - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg    <= rfps_pkg::ROT_0;
            page_select_reg <= rfps_pkg::PAGE_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == rfps_pkg::CFG_ROTATION)
            begin
                rotation_reg <= cfg_data[rfps_pkg::ROT_W-1:0];
            end
            else if (cfg_index == rfps_pkg::CFG_PAGE_SELECT)
            begin
                page_select_reg <= cfg_data[rfps_pkg::PAGE_W-1:0];
            end
        end
    end

    // Word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            black_reg <= (colour == '0);
            bidx_reg  <= byte_index;
        end
    end

    // Bounds check, rotation and page band
    always_comb
    begin
        logic [POS_W-1:0]   lw;
        logic [POS_W-1:0]   lh;
        logic               in_panel;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic               page_mode;
        logic [SUB_W-1:0]   off;
        logic [SUB_W-1:0]   ny_ext;
        logic [SUB_W-1:0]   ydiff;
        logic               in_band;

        lw = rotation_reg[0] ? POS_W'(rfps_pkg::PANEL_HEIGHT) : POS_W'(rfps_pkg::PANEL_WIDTH);
        lh = rotation_reg[0] ? POS_W'(rfps_pkg::PANEL_WIDTH) : POS_W'(rfps_pkg::PANEL_HEIGHT);
        in_panel = !pos_x_reg[POS_W-1] && (pos_x_reg < lw)
                && !pos_y_reg[POS_W-1] && (pos_y_reg < lh);
        xs = pos_x_reg[COORD_W-1:0];
        ys = pos_y_reg[COORD_W-1:0];

        case (rotation_reg)
            rfps_pkg::ROT_90:
            begin
                nx = COORD_W'(rfps_pkg::PANEL_WIDTH - 1) - ys;
                ny = xs;
            end
            rfps_pkg::ROT_180:
            begin
                nx = COORD_W'(rfps_pkg::PANEL_WIDTH - 1) - xs;
                ny = COORD_W'(rfps_pkg::PANEL_HEIGHT - 1) - ys;
            end
            rfps_pkg::ROT_270:
            begin
                nx = ys;
                ny = COORD_W'(rfps_pkg::PANEL_HEIGHT - 1) - xs;
            end
            default:
            begin
                nx = xs;
                ny = ys;
            end
        endcase

        // page 1 or more: shift y into the band
        page_mode = !page_select_reg[rfps_pkg::PAGE_W-1]
                 && (page_select_reg[rfps_pkg::PAGE_W-2:0] != '0);
        off    = SUB_W'(page_select_reg[rfps_pkg::PAGE_W-2:0])
               * SUB_W'(rfps_pkg::BAND_HEIGHT);
        ny_ext = SUB_W'(ny);
        ydiff  = ny_ext - off;
        in_band = (ny_ext >= off) && (ydiff < SUB_W'(rfps_pkg::BAND_HEIGHT));

        map_x_next  = nx;
        map_y_next  = page_mode ? Y_W'(ydiff) : Y_W'(ny);
        map_ok_next = in_panel && (!page_mode || in_band);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rfps_pkg::ST_MAP)
        begin
            map_x_reg  <= map_x_next;
            map_y_reg  <= map_y_next;
            map_ok_reg <= map_ok_next;
        end
    end

    // Byte index and bit mask
    always_comb
    begin
        if (cmd_reg == rfps_pkg::CMD_PLOT)
        begin
            idx_full = IDX_W'(map_x_reg >> 3)
                     + IDX_W'(map_y_reg) * IDX_W'(rfps_pkg::ROW_BYTES);
            hit_next = map_ok_reg && (idx_full < IDX_W'(rfps_pkg::STORE_BYTES));
        end
        else
        begin
            idx_full = IDX_W'(bidx_reg);
            hit_next = (idx_full < IDX_W'(rfps_pkg::STORE_BYTES));
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rfps_pkg::ST_INDEX)
        begin
            idx_reg  <= idx_full[ADDR_W-1:0];
            hit_reg  <= hit_next;
            mask_reg <= 8'h80 >> map_x_reg[2:0];
        end
    end

    // Store: one port, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Sweep counter and fill value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            fill_val_reg  <= 8'h00;
        end
        else if (state_reg == rfps_pkg::ST_SWEEP)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
        end
        else if (out_load && (cmd_reg == rfps_pkg::CMD_FILL))
        begin
            sweep_cnt_reg <= '0;
            fill_val_reg  <= black_reg ? 8'hFF : 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rfps_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = rfps_pkg::ST_IDLE;
                end
            end
            rfps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rfps_pkg::ST_MAP;
                end
            end
            rfps_pkg::ST_MAP:   state_next = rfps_pkg::ST_INDEX;
            rfps_pkg::ST_INDEX: state_next = rfps_pkg::ST_READ;
            rfps_pkg::ST_READ:  state_next = rfps_pkg::ST_WRITE;
            rfps_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = (cmd_reg == rfps_pkg::CMD_FILL) ? rfps_pkg::ST_SWEEP
                                                                 : rfps_pkg::ST_IDLE;
                end
            end
            default: state_next = rfps_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = black_reg ? (rd_data_reg | mask_reg) : (rd_data_reg & ~mask_reg);
        out_load  = 1'b0;
        case (state_reg)
            rfps_pkg::ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_addr  = sweep_cnt_reg;
                mem_wdata = fill_val_reg;
            end
            rfps_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            rfps_pkg::ST_WRITE:
            begin
                out_load = out_free;
                mem_we   = out_free && hit_reg && (cmd_reg == rfps_pkg::CMD_PLOT);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfps_pkg::ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_byte_reg   <= 8'h00;
            pixel_taken_reg <= 1'b0;
            if (cmd_reg == rfps_pkg::CMD_READ)
            begin
                read_byte_reg <= hit_reg ? ~rd_data_reg : 8'hFF;
            end
            else if (cmd_reg == rfps_pkg::CMD_PLOT)
            begin
                pixel_taken_reg <= hit_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_byte   = read_byte_reg;
    assign pixel_taken = pixel_taken_reg;

    // Checks
    `ASSERT_IMP(a_we_state, mem_we,
        (state_reg == rfps_pkg::ST_WRITE) || (state_reg == rfps_pkg::ST_SWEEP),
        "store written outside write or sweep")
    `ASSERT_IMP(a_load_free, out_load, !out_valid_reg || !out_stall,
        "result overwrote an untaken word")
    `ASSERT_IMP(a_taken_zero, out_valid_reg && pixel_taken_reg, read_byte_reg == 8'h00,
        "plot result carries read data")
    `ASSERT_IMP(a_sweep_range, state_reg == rfps_pkg::ST_SWEEP,
        sweep_cnt_reg < ADDR_W'(rfps_pkg::STORE_BYTES),
        "sweep address past store")
    `ASSERT_NXT(a_accept_map, accept, state_reg == rfps_pkg::ST_MAP,
        "accepted word did not enter mapping")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for rotated_framebuffer_pixel_store_top: directed and random plot, fill,
// read and no-op words checked against a behavioural copy of the frame store.
// Depends on rfps_pkg and the frame store RTL.
module tb_top;
    import rfps_pkg::*;

    // Register indexes past the two real registers; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int WATCHDOG_LIMIT = 4 * STORE_BYTES + 1000;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [COLOUR_W-1:0] colour;
        logic [BIDX_W-1:0]   byte_index;
    } draw_word_t;

    localparam int WORD_W = $bits(draw_word_t);

    typedef struct packed {
        logic [7:0] read_byte;
        logic       pixel_taken;
    } readout_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      command = CMD_NOP;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic [COLOUR_W-1:0]   colour = '0;
    logic [BIDX_W-1:0]     byte_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            read_byte;
    logic                  pixel_taken;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Behavioural copy of the store and its registers
    logic [7:0]              shadow_frame [STORE_BYTES];
    logic [ROT_W-1:0]        shadow_rot = ROT_0;
    logic signed [PAGE_W-1:0] shadow_page = PAGE_RESET;

    draw_word_t draw_queue[$];
    readout_t   awaited_readouts[$];
    int         words_in_flight = 0;
    bit         word_taken = 1'b0;
    bit         quiet = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         idle_cycles = 0;
    int         mismatches = 0;
    int         n_plots = 0;
    int         n_landed = 0;
    int         n_reads = 0;
    int         n_fills = 0;
    int         n_nops = 0;
    int         n_settings = 0;

    rotated_framebuffer_pixel_store_top dut (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        foreach (shadow_frame[i])
            shadow_frame[i] = 8'h00;
    end

    // Maps a logical point to a store byte and bit; 0 when the pixel is dropped
    function automatic bit locate_pixel(input int px, input int py,
                                        output int idx, output int bitpos);
        int lw;
        int lh;
        int t;
        int page_n;
        lw = shadow_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = shadow_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        page_n = int'(shadow_page);
        idx = 0;
        bitpos = 0;
        if (px < 0 || px >= lw || py < 0 || py >= lh)
            return 1'b0;
        case (shadow_rot)
            ROT_90:
            begin
                t = px;
                px = PANEL_WIDTH - 1 - py;
                py = t;
            end
            ROT_180:
            begin
                px = PANEL_WIDTH - 1 - px;
                py = PANEL_HEIGHT - 1 - py;
            end
            ROT_270:
            begin
                t = px;
                px = py;
                py = PANEL_HEIGHT - 1 - t;
            end
            default: ;
        endcase
        // paged drawing: only the selected band lands
        if (page_n >= 1)
        begin
            py = py - page_n * BAND_HEIGHT;
            if (py < 0 || py >= BAND_HEIGHT)
                return 1'b0;
        end
        idx = px / 8 + py * (PANEL_WIDTH / 8);
        if (idx >= STORE_BYTES)
            return 1'b0;
        bitpos = 7 - (px % 8);
        return 1'b1;
    endfunction

    // Applies one word to the copy of the store and gives the readout it causes
    function automatic readout_t frame_readout(input draw_word_t w);
        readout_t r;
        int idx;
        int bitpos;
        r = '0;
        case (w.command)
            CMD_PLOT:
                if (locate_pixel(int'($signed(w.pos_x)), int'($signed(w.pos_y)),
                                 idx, bitpos))
                begin
                    shadow_frame[idx][bitpos] = (w.colour == '0);
                    r.pixel_taken = 1'b1;
                end
            CMD_FILL:
                foreach (shadow_frame[i])
                    shadow_frame[i] = (w.colour == '0) ? 8'hFF : 8'h00;
            CMD_READ:
                r.read_byte = (w.byte_index < STORE_BYTES) ? ~shadow_frame[w.byte_index]
                                                          : 8'hFF;
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input int x, input int y,
                              input int c, input int b);
        draw_queue.push_back({cmd, POS_W'(x), POS_W'(y), COLOUR_W'(c), BIDX_W'(b)});
        words_in_flight++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_ROTATION)
            shadow_rot = data[ROT_W-1:0];
        else if (idx == CFG_PAGE_SELECT)
            shadow_page = data[PAGE_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [ROT_W-1:0] rot, input int page);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, junk);
        // upper data bits are don't-care for the rotation register
        write_reg(CFG_ROTATION, {junk[CFG_DATA_W-1:ROT_W], rot});
        write_reg(CFG_PAGE_SELECT, PAGE_W'(page));
        n_settings++;
    endtask

    // Waits for every readout, then for any fill sweep still walking the store
    task automatic settle();
        while (words_in_flight != 0 || awaited_readouts.size() != 0)
            @(negedge clk);
        repeat (STORE_BYTES + 20) @(negedge clk);
    endtask

    task automatic queue_directed();
        queue_word(CMD_READ, 0, 0, 0, 0);
        queue_word(CMD_PLOT, 0, 0, 0, 0);
        queue_word(CMD_READ, 0, 0, 0, 0);
        queue_word(CMD_PLOT, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0);
        queue_word(CMD_READ, 0, 0, 0, STORE_BYTES - 1);
        // off-panel points are dropped
        queue_word(CMD_PLOT, 16'hFFFF, 0, 0, 0);
        queue_word(CMD_PLOT, PANEL_WIDTH, 0, 0, 0);
        queue_word(CMD_PLOT, 0, PANEL_HEIGHT, 0, 0);
        queue_word(CMD_PLOT, 16'h8000, 16'h7FFF, 0, 0);
        queue_word(CMD_PLOT, 16'h7FFF, 16'h8000, 0, 0);
        // white clears; white on white still counts as written
        queue_word(CMD_PLOT, 0, 0, 16'hFFFF, 0);
        queue_word(CMD_PLOT, 7, 0, 16'h0001, 0);
        queue_word(CMD_READ, 0, 0, 0, 0);
        // reads past the store
        queue_word(CMD_READ, 0, 0, 0, STORE_BYTES);
        queue_word(CMD_READ, 0, 0, 0, 13'h1FFF);
        queue_word(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        queue_word(CMD_FILL, 0, 0, 0, 0);
        queue_word(CMD_READ, 0, 0, 0, 100);
        queue_word(CMD_PLOT, 9, 1, 16'h8000, 0);
        queue_word(CMD_READ, 0, 0, 0, 23);
        queue_word(CMD_FILL, 16'hFFFF, 16'hFFFF, 16'h8000, 13'h1FFF);
        queue_word(CMD_READ, 0, 0, 0, 100);
    endtask

    function automatic logic [POS_W-1:0] pick_coord(input int limit);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return POS_W'(limit - 1);
            2: return POS_W'(limit);
            3: return '1;
            default: return POS_W'($urandom_range(0, limit - 1));
        endcase
    endfunction

    // Mostly on-panel plots with read-backs of the byte just drawn, plus noise
    task automatic queue_random(input int count);
        draw_word_t w;
        int pushed;
        int r;
        int idx;
        int bitpos;
        pushed = 0;
        while (pushed < count)
        begin
            w = WORD_W'({$urandom, $urandom});
            r = $urandom_range(0, 199);
            if (r == 0)
                w.command = CMD_FILL;
            else if (r < 110)
                w.command = CMD_PLOT;
            else if (r < 188)
                w.command = CMD_READ;
            else
                w.command = CMD_NOP;
            if (w.command == CMD_PLOT && $urandom_range(0, 6) != 0)
            begin
                w.pos_x = pick_coord(shadow_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH);
                w.pos_y = pick_coord(shadow_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT);
            end
            if ($urandom_range(0, 1) != 0)
                w.colour = '0;
            else if ($urandom_range(0, 1) != 0)
                w.colour = COLOUR_W'($urandom_range(1, 3));
            if (w.command == CMD_READ && $urandom_range(0, 4) != 0)
                w.byte_index = BIDX_W'($urandom_range(0, STORE_BYTES - 1));
            draw_queue.push_back(w);
            words_in_flight++;
            pushed++;
            if (w.command == CMD_PLOT && $urandom_range(0, 2) != 0 &&
                locate_pixel(int'($signed(w.pos_x)), int'($signed(w.pos_y)), idx, bitpos))
            begin
                queue_word(CMD_READ, $urandom, $urandom, $urandom, idx);
                pushed++;
            end
        end
    endtask

    task automatic run_phase(input logic [ROT_W-1:0] rot, input int page, input int count);
        settle();
        set_config(rot, page);
        queue_random(count);
    endtask

    // Sequence of phases: reset settings, then rotations and page bands
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        queue_directed();
        queue_random(280);
        run_phase(ROT_90, -1, 240);
        run_phase(ROT_180, 0, 240);
        run_phase(ROT_270, 15, 120);
        run_phase(ROT_270, -16, 240);
        run_phase(ROT_0, 1, 120);
        run_phase(ROT_180, -1, 240);
        quiet = 1'b1;
        run_phase(ROT_90, -1, 300);
        while (words_in_flight != 0 || awaited_readouts.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        $display("covered %0d plots (%0d landed), %0d reads, %0d fills, %0d no-ops",
                 n_plots, n_landed, n_reads, n_fills, n_nops);
        $display("over %0d register settings after reset, %0d mismatches",
                 n_settings, mismatches);
        if (mismatches == 0 && awaited_readouts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Input driver: holds a word until taken, idles in random bursts
    always @(negedge clk)
    begin
        draw_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || word_taken)
        begin
            word_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                in_gap = $urandom_range(1, 13) - 1;
                in_valid <= 1'b0;
            end
            else if (draw_queue.size() != 0)
            begin
                w = draw_queue.pop_front();
                in_valid   <= 1'b1;
                command    <= w.command;
                pos_x      <= w.pos_x;
                pos_y      <= w.pos_y;
                colour     <= w.colour;
                byte_index <= w.byte_index;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output back-pressure in random bursts
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 14) == 0)
        begin
            out_gap = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predicts on each taken word, checks each readout in order
    always @(posedge clk)
    begin
        draw_word_t w;
        readout_t   got;
        readout_t   want;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                w = {command, pos_x, pos_y, colour, byte_index};
                want = frame_readout(w);
                awaited_readouts.push_back(want);
                words_in_flight--;
                word_taken = 1'b1;
                moved = 1'b1;
                case (w.command)
                    CMD_PLOT:
                    begin
                        n_plots++;
                        n_landed += want.pixel_taken;
                    end
                    CMD_FILL: n_fills++;
                    CMD_READ: n_reads++;
                    default:  n_nops++;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = {read_byte, pixel_taken};
                if (awaited_readouts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: readout %h/%b with none expected",
                                 $time, got.read_byte, got.pixel_taken);
                end
                else
                begin
                    want = awaited_readouts.pop_front();
                    if (got.read_byte !== want.read_byte)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: read_byte expected %h, got %h",
                                     $time, want.read_byte, got.read_byte);
                    end
                    if (got.pixel_taken !== want.pixel_taken)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: pixel_taken expected %b, got %b",
                                     $time, want.pixel_taken, got.pixel_taken);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
